// ===== src/tccb_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cell buffer package
// Request kinds, control characters, register map and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tccb_pkg;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Control characters recognized by a put.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_SCROLL  = 2'd2;

    localparam int COL_W    = 8;
    localparam int ROWS_W   = 8;
    localparam int SCROLL_W = 12;
    localparam int START_W  = SCROLL_W + COL_W;
    localparam int ROFF_W   = ROWS_W + COL_W;
    localparam int IDX_W    = START_W + 1;

    localparam logic [COL_W-1:0]    COLUMNS_RESET = 8'd80;
    localparam logic [ROWS_W-1:0]   ROWS_RESET    = 8'd25;
    localparam logic [SCROLL_W-1:0] SCROLL_RESET  = 12'd0;

    // Result of the column remainder unit.
    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] rem;
    } mod_result_t;

endpackage

`default_nettype wire

// ===== src/tccb_col_mod.sv =====
// ----------------------------------------------------------------------------
// Column remainder unit
// Bit-serial restoring remainder of the write pointer by the column count.
// ----------------------------------------------------------------------------
`default_nettype none

module tccb_col_mod #(
    parameter int PTR_W = 13
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire  [PTR_W-1:0]          dividend,
    input  wire  [tccb_pkg::COL_W-1:0] divisor,
    output tccb_pkg::mod_result_t     result
);
    import tccb_pkg::*;

    localparam int CNT_W = $clog2(PTR_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PTR_W-1:0] dvd_reg;
    logic [COL_W-1:0] rem_reg;
    logic [COL_W:0]   trial;
    logic [COL_W-1:0] rem_next;

    // One quotient bit per cycle, most significant bit first.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[PTR_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = COL_W'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PTR_W);
                dvd_reg  <= dividend;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[PTR_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign result.done = done_reg;
    assign result.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== src/text_console_cell_buffer_top.sv =====
// A printable byte, newline, carriage return or backspace passes the put step and then
// issues its word, with the column remainder step first after a columns write; a read steps
// through multiply, address and memory read; a tab adds a sum, a phase and a pad per cell.
// A clear walks the cell memory one entry per cycle.
// After reset the same sweep runs with s_axis_tready low.
// One request is in flight at a time; the next is taken once its word is issued.
// ----------------------------------------------------------------------------
// Text console cell buffer
// Character cell store with write pointer, control characters and display reads.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_buffer_top #(
    parameter int STORE_CELLS = 4096,
    parameter int TAB_STOP    = 4,
    localparam int PTR_W      = $clog2(STORE_CELLS + 1),
    localparam int OUT_W      = ((9 + PTR_W + 7) / 8) * 8
) (
    input  wire              clk,
    input  wire              rst_n,
    // APB configuration port
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [3:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Request stream
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire  [23:0]      s_axis_tdata,  // char_code, screen_row, screen_col
    input  wire  [1:0]       s_axis_tuser,  // kind
    // Result stream
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // cell_char, cell_visible, write_position
);
    import tccb_pkg::*;

    localparam int ADDR_W = $clog2(STORE_CELLS);
    localparam int TSUM_W = $clog2(PTR_W * (TAB_STOP - 1) + 1);
    localparam int TPH_W  = $clog2(TAB_STOP + 1);
    localparam logic [PTR_W-1:0]  STORE_PTR  = PTR_W'(STORE_CELLS);
    localparam logic [IDX_W-1:0]  STORE_IDX  = IDX_W'(STORE_CELLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_CELLS - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_MOD, S_PUT, S_TAB_SUM, S_TAB_MOD, S_TAB_WR,
        S_RD_MUL, S_RD_ADDR, S_RD_DATA, S_CLEAR, S_DONE
    } state_t;

    // Weighted sum of pointer bits; each weight is that bit's value mod the tab stop.
    function automatic logic [TSUM_W-1:0] tab_weight_sum(input logic [PTR_W-1:0] p);
        logic [TSUM_W-1:0] s;
        s = '0;
        for (int k = 0; k < PTR_W; k++)
        begin
            if (p[k])
            begin
                s = s + TSUM_W'((1 << k) % TAB_STOP);
            end
        end
        return s;
    endfunction

    function automatic logic [TPH_W-1:0] tab_phase(input logic [TSUM_W-1:0] s);
        logic [TPH_W-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << TSUM_W); i++)
        begin
            if (s == TSUM_W'(i))
            begin
                r = TPH_W'(i % TAB_STOP);
            end
        end
        return r;
    endfunction

    // Configuration registers
    logic [COL_W-1:0]    columns_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic [SCROLL_W-1:0] scroll_reg;
    logic                cfg_write;
    logic                col_dirty_reg;

    // Control state
    state_t              state_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ADDR_W-1:0]   clr_idx_reg;
    logic [TSUM_W-1:0]   tab_sum_reg;
    logic [TPH_W-1:0]    tab_left_reg;

    // Request and result
    logic [7:0]          char_req_reg;
    logic [7:0]          row_req_reg;
    logic [7:0]          scol_req_reg;
    logic [START_W-1:0]  start_reg;
    logic [ROFF_W-1:0]   roff_reg;
    logic                rd_vis_reg;
    logic [7:0]          res_char_reg;
    logic                res_vis_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;

    // Cell memory
    logic [7:0]          cell_mem [STORE_CELLS];
    logic [7:0]          rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;

    logic [COL_W-1:0]    eff_w;
    logic                in_accept;
    logic                wrap;
    logic [COL_W-1:0]    col_inc;
    logic [PTR_W:0]      nl_sum;
    logic [IDX_W-1:0]    rd_idx;
    logic                rd_vis;
    logic                clr_last;
    logic                mod_start;
    logic                dirty_clr;
    mod_result_t         mod_res;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COLUMNS: prdata = 32'(columns_reg);
            REG_ROWS:    prdata = 32'(rows_reg);
            REG_SCROLL:  prdata = 32'(scroll_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            scroll_reg  <= SCROLL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_COLUMNS: columns_reg <= pwdata[COL_W-1:0];
                REG_ROWS:    rows_reg    <= pwdata[ROWS_W-1:0];
                REG_SCROLL:  scroll_reg  <= pwdata[SCROLL_W-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign eff_w     = (columns_reg == '0) ? COL_W'(1) : columns_reg;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign wrap      = (wp_reg == STORE_PTR);
    assign col_inc   = ((col_reg + COL_W'(1)) == eff_w) ? '0 : col_reg + COL_W'(1);
    assign nl_sum    = {1'b0, wp_reg} + (PTR_W + 1)'(eff_w - col_reg);
    assign clr_last  = (clr_idx_reg == LAST_ADDR);

    assign rd_idx = IDX_W'(start_reg) + IDX_W'(roff_reg) + IDX_W'(scol_req_reg);
    assign rd_vis = (IDX_W'(start_reg) < STORE_IDX) && (scol_req_reg < eff_w)
                 && (row_req_reg < rows_reg) && (rd_idx < IDX_W'(wp_reg))
                 && (rd_idx < STORE_IDX);

    // Column count is rebuilt only when the column register changed since last use.
    assign mod_start = in_accept && (s_axis_tuser == KIND_PUT)
                    && (s_axis_tdata[7:0] != CH_NUL) && !wrap && col_dirty_reg;

    // A clear or a wrap leaves the pointer at zero, where any column width gives column 0.
    assign dirty_clr = (in_accept && (s_axis_tuser == KIND_CLEAR
                                      || (s_axis_tuser == KIND_PUT
                                          && s_axis_tdata[7:0] != CH_NUL && wrap)))
                    || (state_reg == S_MOD && mod_res.done);

    tccb_col_mod #(
        .PTR_W (PTR_W)
    ) u_col_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (wp_reg),
        .divisor  (eff_w),
        .result   (mod_res)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wp_reg[ADDR_W-1:0];
        mem_wdata = char_req_reg;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
            end
            S_PUT:
            begin
                if (char_req_reg == CH_BS)
                begin
                    mem_we    = (wp_reg != '0);
                    mem_wdata = '0;
                end
                else if (char_req_reg != CH_NL && char_req_reg != CH_CR
                         && char_req_reg != CH_TAB)
                begin
                    mem_we = 1'b1;
                end
            end
            S_TAB_WR:
            begin
                mem_we    = (tab_left_reg != '0) && (wp_reg != STORE_PTR);
                mem_wdata = CH_SPACE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[rd_idx[ADDR_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            wp_reg        <= '0;
            col_reg       <= '0;
            col_dirty_reg <= 1'b0;
            clr_idx_reg   <= '0;
            tab_sum_reg   <= '0;
            tab_left_reg  <= '0;
            char_req_reg  <= '0;
            row_req_reg   <= '0;
            scol_req_reg  <= '0;
            start_reg     <= '0;
            roff_reg      <= '0;
            rd_vis_reg    <= 1'b0;
            res_char_reg  <= '0;
            res_vis_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            // In S_DONE the output register is reloaded below instead.
            if (m_valid_reg && m_axis_tready && state_reg != S_DONE)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_write && paddr[3:2] == REG_COLUMNS)
            begin
                col_dirty_reg <= 1'b1;
            end
            else if (dirty_clr)
            begin
                col_dirty_reg <= 1'b0;
            end

            unique case (state_reg)
                S_INIT:
                begin
                    if (clr_last)
                    begin
                        clr_idx_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
                    end
                end

                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        char_req_reg <= s_axis_tdata[7:0];
                        row_req_reg  <= s_axis_tdata[15:8];
                        scol_req_reg <= s_axis_tdata[23:16];
                        res_char_reg <= '0;
                        res_vis_reg  <= 1'b0;
                        unique case (s_axis_tuser)
                            KIND_PUT:
                            begin
                                if (s_axis_tdata[7:0] == CH_NUL)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else if (wrap)
                                begin
                                    // Pointer at the end wraps to the start before the put is carried out.
                                    wp_reg    <= '0;
                                    col_reg   <= '0;
                                    state_reg <= S_PUT;
                                end
                                else if (col_dirty_reg)
                                begin
                                    state_reg <= S_MOD;
                                end
                                else
                                begin
                                    state_reg <= S_PUT;
                                end
                            end
                            KIND_READ:
                            begin
                                state_reg <= S_RD_MUL;
                            end
                            KIND_CLEAR:
                            begin
                                wp_reg    <= '0;
                                col_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_MOD:
                begin
                    if (mod_res.done)
                    begin
                        col_reg   <= mod_res.rem;
                        state_reg <= S_PUT;
                    end
                end

                S_PUT:
                begin
                    state_reg <= S_DONE;
                    priority if (char_req_reg == CH_NL)
                    begin
                        // Past the end the column count is unused: the next put wraps.
                        wp_reg  <= (nl_sum > {1'b0, STORE_PTR}) ? STORE_PTR
                                                                : nl_sum[PTR_W-1:0];
                        col_reg <= '0;
                    end
                    else if (char_req_reg == CH_BS)
                    begin
                        if (wp_reg != '0)
                        begin
                            wp_reg  <= wp_reg - PTR_W'(1);
                            col_reg <= (col_reg == '0) ? eff_w - COL_W'(1)
                                                       : col_reg - COL_W'(1);
                        end
                    end
                    else if (char_req_reg == CH_CR)
                    begin
                        wp_reg  <= wp_reg - PTR_W'(col_reg);
                        col_reg <= '0;
                    end
                    else if (char_req_reg == CH_TAB)
                    begin
                        state_reg <= S_TAB_SUM;
                    end
                    else
                    begin
                        wp_reg  <= wp_reg + PTR_W'(1);
                        col_reg <= col_inc;
                    end
                end

                S_TAB_SUM:
                begin
                    tab_sum_reg <= tab_weight_sum(wp_reg);
                    state_reg   <= S_TAB_MOD;
                end

                S_TAB_MOD:
                begin
                    tab_left_reg <= TPH_W'(TAB_STOP) - tab_phase(tab_sum_reg);
                    state_reg    <= S_TAB_WR;
                end

                S_TAB_WR:
                begin
                    if (tab_left_reg != '0 && wp_reg != STORE_PTR)
                    begin
                        wp_reg       <= wp_reg + PTR_W'(1);
                        col_reg      <= col_inc;
                        tab_left_reg <= tab_left_reg - TPH_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_RD_MUL:
                begin
                    start_reg <= START_W'(scroll_reg) * START_W'(eff_w);
                    roff_reg  <= ROFF_W'(row_req_reg) * ROFF_W'(eff_w);
                    state_reg <= S_RD_ADDR;
                end

                S_RD_ADDR:
                begin
                    rd_vis_reg <= rd_vis;
                    state_reg  <= S_RD_DATA;
                end

                S_RD_DATA:
                begin
                    res_vis_reg <= rd_vis_reg;
                    if (rd_vis_reg)
                    begin
                        res_char_reg <= (rd_data_reg == CH_NUL) ? CH_SPACE : rd_data_reg;
                    end
                    state_reg <= S_DONE;
                end

                S_CLEAR:
                begin
                    if (clr_last)
                    begin
                        clr_idx_reg <= '0;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
                    end
                end

                S_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= OUT_W'({wp_reg, res_vis_reg, res_char_reg});
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= STORE_PTR)
        else $error("write pointer beyond the store");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        !col_dirty_reg |-> (col_reg < eff_w))
        else $error("column count not below the column width");

    a_tab_range: assert property (@(posedge clk) disable iff (!rst_n)
        tab_left_reg <= TPH_W'(TAB_STOP))
        else $error("tab pad count beyond the tab stop");

    a_clear_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_last) |=> (wp_reg == '0 && state_reg == S_DONE))
        else $error("clear finished without a zero pointer");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_ADDR || state_reg == S_RD_DATA) |-> !mem_we)
        else $error("cell write during a display read");

endmodule

`default_nettype wire

// ===== test/tb_text_console_cell_buffer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console cell buffer testbench
// Streams put, read, clear and unused-kind requests into the cell buffer under
// several screen geometries. A shadow copy of the cell store predicts each
// result word, and every returned word is compared field by field in order.
// ----------------------------------------------------------------------------

module tb_text_console_cell_buffer_top;

    import tccb_pkg::*;

    localparam int STORE_CELLS      = 4096;
    localparam int TAB_STOP         = 4;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int SETTLE_CYCLES    = 24;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_IDLE         = 16;
    localparam int SESSIONS         = 8;
    localparam int SESSION_WORDS    = 175;

    typedef struct packed {
        logic [12:0] pos;
        logic        vis;
        logic [7:0]  ch;
    } cell_word_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // char_code, screen_row, screen_col
    logic [1:0]  s_axis_tuser  = '0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // cell_char, cell_visible, write_position

    text_console_cell_buffer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow state of the console.
    logic [7:0]     shadow_cells [STORE_CELLS];
    int unsigned    shadow_ptr   = 0;
    logic [7:0]     cfg_columns  = COLUMNS_RESET;
    logic [7:0]     cfg_rows     = ROWS_RESET;
    logic [11:0]    cfg_scroll   = SCROLL_RESET;

    cell_word_t     expected_words[$];
    int             mismatches   = 0;
    int             words_seen   = 0;
    int             cycle_count  = 0;
    bit             tx_idle      = 1'b1;
    bit             rx_idle      = 1'b1;
    int             rx_stall_left = 0;
    logic           rx_hold      = 1'b0;
    bit             hold_request = 1'b0;
    int             newline_weight = 8;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (shadow_cells[i])
            shadow_cells[i] = 8'h00;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on word %0d, %s: got 0x%0h, expected 0x%0h",
                 words_seen, what, got, want);
        mismatches++;
    endtask

    // Advances the shadow console by one request and returns the word it should produce.
    function automatic cell_word_t predict_console(input logic [1:0] kind,
                                                   input logic [7:0] ch,
                                                   input logic [7:0] row,
                                                   input logic [7:0] col);
        cell_word_t  word;
        int unsigned w;
        int unsigned colpos;
        int unsigned pad;
        int unsigned start;
        int unsigned idx;
        word = '0;
        w = (cfg_columns == 8'd0) ? 1 : cfg_columns;
        case (kind)
            KIND_PUT:
            begin
                if (ch != CH_NUL)
                begin
                    if (shadow_ptr >= STORE_CELLS)
                        shadow_ptr = 0;
                    colpos = shadow_ptr % w;
                    case (ch)
                        CH_NL:
                        begin
                            shadow_ptr += w - colpos;
                            if (shadow_ptr > STORE_CELLS)
                                shadow_ptr = STORE_CELLS;
                        end
                        CH_BS:
                        begin
                            // The slot at the pointer is erased, not the one behind it.
                            if (shadow_ptr > 0)
                            begin
                                shadow_cells[shadow_ptr] = 8'h00;
                                shadow_ptr--;
                            end
                        end
                        CH_CR:
                            shadow_ptr -= colpos;
                        CH_TAB:
                        begin
                            pad = TAB_STOP - (shadow_ptr % TAB_STOP);
                            for (int s = 0; s < pad && shadow_ptr < STORE_CELLS; s++)
                            begin
                                shadow_cells[shadow_ptr] = CH_SPACE;
                                shadow_ptr++;
                            end
                        end
                        default:
                        begin
                            shadow_cells[shadow_ptr] = ch;
                            shadow_ptr++;
                        end
                    endcase
                end
            end
            KIND_READ:
            begin
                start = cfg_scroll * w;
                if (start < STORE_CELLS && col < w && row < cfg_rows)
                begin
                    idx = start + row * w + col;
                    if (idx < shadow_ptr && idx < STORE_CELLS)
                    begin
                        word.ch  = (shadow_cells[idx] == 8'h00) ? CH_SPACE : shadow_cells[idx];
                        word.vis = 1'b1;
                    end
                end
            end
            KIND_CLEAR:
            begin
                foreach (shadow_cells[i])
                    shadow_cells[i] = 8'h00;
                shadow_ptr = 0;
            end
            default:
                ;
        endcase
        word.pos = shadow_ptr[12:0];
        return word;
    endfunction

    task automatic check_word(input logic [23:0] data);
        cell_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("word with nothing pending", data, 0);
        end
        else
        begin
            want = expected_words.pop_front();
            if (data[7:0] !== want.ch)
                report_mismatch("cell_char", data[7:0], want.ch);
            if (data[8] !== want.vis)
                report_mismatch("cell_visible", data[8], want.vis);
            if (data[21:9] !== want.pos)
                report_mismatch("write_position", data[21:9], want.pos);
        end
        words_seen++;
    endtask

    // Result side: a random stall after every word while rx_idle is set, plus the long hold-off when requested.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            check_word(m_axis_tdata);
            rx_stall_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end
        if (rx_hold || rx_stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            if (!rx_hold)
                rx_stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rx_hold <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
                hold_request = 1'b0;
            end
        end
    end

    // The valid flag stays high after a word is taken, so a back-to-back word needs
    // only one assignment; a random gap or wait_drained lowers it for a pause.
    task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [7:0] row, input logic [7:0] col);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {col, row, ch};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_words.push_back(predict_console(kind, ch, row, col));
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_word(KIND_PUT, ch, 8'($urandom), 8'($urandom));
    endtask

    task automatic read_cell(input logic [7:0] row, input logic [7:0] col);
        send_word(KIND_READ, 8'($urandom), row, col);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register, reads it straight back, and updates the shadow geometry.
    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_COLUMNS: cfg_columns = value[7:0];
            REG_ROWS:    cfg_rows    = value[7:0];
            REG_SCROLL:  cfg_scroll  = value[11:0];
            default:     ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COLUMNS: want = {24'd0, cfg_columns};
            REG_ROWS:    want = {24'd0, cfg_rows};
            default:     want = {20'd0, cfg_scroll};
        endcase
        if (readback !== want)
            report_mismatch("register readback", readback, want);
    endtask

    task automatic set_geometry(input logic [7:0] columns, input logic [7:0] rows,
                                input logic [11:0] scroll);
        wait_drained();
        program_register(REG_COLUMNS, {24'd0, columns});
        program_register(REG_ROWS, {24'd0, rows});
        program_register(REG_SCROLL, {20'd0, scroll});
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < newline_weight)
            return CH_NL;
        else if (r < newline_weight + 8)
            return CH_TAB;
        else if (r < newline_weight + 14)
            return CH_BS;
        else if (r < newline_weight + 19)
            return CH_CR;
        else if (r < newline_weight + 21)
            return CH_NUL;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_random_request();
        int          r;
        int          sel;
        int unsigned w;
        int unsigned start;
        int unsigned off;
        int unsigned row;
        int unsigned col;
        r = $urandom_range(0, 99);
        w = (cfg_columns == 8'd0) ? 1 : cfg_columns;
        start = cfg_scroll * w;
        if (r < 1)
        begin
            send_word(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        else if (r < 3)
        begin
            send_word(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        else if (r < 60)
        begin
            put_char(pick_char());
        end
        else
        begin
            sel = $urandom_range(0, 9);
            row = $urandom_range(0, 255);
            col = $urandom_range(0, 255);
            if (sel < 5 && start < shadow_ptr && start < STORE_CELLS)
            begin
                // Aim at a written cell so that most reads come back visible.
                off = $urandom_range(0, shadow_ptr - start - 1);
                if (off / w < 256)
                begin
                    row = off / w;
                    col = off % w;
                end
            end
            else if (sel < 8)
            begin
                row = $urandom_range(0, cfg_rows);
                col = $urandom_range(0, w);
            end
            read_cell(row[7:0], col[7:0]);
        end
    endtask

    task automatic test_directed_edits();
        read_cell(8'd0, 8'd0);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(CH_NUL);
        put_char(CH_TAB);
        put_char(CH_BS);
        read_cell(8'd0, 8'd0);
        read_cell(8'd0, 8'd2);
        read_cell(8'd0, 8'd79);
        read_cell(8'd0, 8'd80);
        read_cell(8'd25, 8'd0);
        put_char(CH_CR);
        put_char(8'h42);
        put_char(CH_NL);
        send_word(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        read_cell(8'd0, 8'd0);
        send_word(KIND_CLEAR, 8'h00, 8'h00, 8'h00);
        read_cell(8'd0, 8'd0);
    endtask

    task automatic test_geometry_extremes();
        set_geometry(8'd1, 8'd1, 12'd0);
        put_char(8'h78);
        put_char(CH_NL);
        read_cell(8'd0, 8'd0);
        read_cell(8'd1, 8'd0);
        // Zero columns act as one column; zero rows hide everything.
        set_geometry(8'd0, 8'd0, 12'd0);
        put_char(8'h79);
        read_cell(8'd0, 8'd0);
        set_geometry(8'd255, 8'd255, 12'd4095);
        read_cell(8'd0, 8'd0);
    endtask

    task automatic test_backpressure();
        set_geometry(8'd40, 8'd30, 12'd0);
        tx_idle = 1'b0;
        hold_request = 1'b1;
        repeat (30) send_random_request();
        wait_drained();
        tx_idle = 1'b1;
    endtask

    task automatic test_pause_and_resume();
        repeat (40) send_random_request();
        wait_drained();
        repeat (40) send_random_request();
    endtask

    task automatic test_random_sessions();
        logic [7:0]  columns;
        logic [7:0]  rows;
        logic [11:0] scroll;
        for (int p = 0; p < SESSIONS; p++)
        begin
            case ($urandom_range(0, 5))
                0:       columns = 8'd1;
                1:       columns = 8'd255;
                2:       columns = 8'($urandom_range(0, 3));
                default: columns = 8'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 4))
                0:       rows = 8'd1;
                1:       rows = 8'd255;
                2:       rows = 8'($urandom_range(0, 255));
                default: rows = 8'($urandom_range(1, 60));
            endcase
            case ($urandom_range(0, 5))
                0:       scroll = 12'd0;
                1:       scroll = 12'd4095;
                2:       scroll = 12'($urandom);
                default: scroll = 12'($urandom_range(0, 8));
            endcase
            set_geometry(columns, rows, scroll);
            if ($urandom_range(0, 1) == 0)
                send_word(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
            // Newline-heavy sessions run the pointer up to the store end and wrap it.
            newline_weight = (p % 3 == 0) ? 40 : 8;
            tx_idle = (p % 4 != 1);
            rx_idle = (p % 4 != 2);
            repeat (SESSION_WORDS) send_random_request();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edits();
        test_geometry_extremes();
        test_backpressure();
        test_pause_and_resume();
        test_random_sessions();
        wait_drained();
        if (expected_words.size() != 0)
            report_mismatch("words never returned", 0, expected_words.size());
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
